[rtl/assert_macros.svh]
// Assertion macros shared by the ringtone parser RTL.
// Included by bare file name; compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define RTNP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rtnp assertion failed");
// Condition that must never be true outside reset.
`define RTNP_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rtnp forbidden condition seen");
`else
`define RTNP_ASSERT(label, clk, rst_n, prop)
`define RTNP_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[rtl/rtnp_pkg.sv]
// Types, constants and helper functions for the ringtone text note parser.
// No dependencies; used by ringtone_text_note_parser_core.
package rtnp_pkg;

  // Octave offset applied to every note before the table lookup.
  localparam int OCTAVE_SHIFT = 0;

  // Reset values of the configuration registers.
  localparam logic [7:0] DEF_DURATION_RST = 8'd4;
  localparam logic [2:0] DEF_OCTAVE_RST   = 3'd6;
  localparam logic [9:0] DEF_TEMPO_RST    = 10'd63;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEF_DURATION = 2'd0;
  localparam logic [1:0] CFG_DEF_OCTAVE   = 2'd1;
  localparam logic [1:0] CFG_DEF_TEMPO    = 2'd2;

  // Number accumulator saturation and whole-note numerator (ms per minute).
  localparam logic [9:0]  ACC_MAX       = 10'd1023;
  localparam logic [17:0] MS_PER_MINUTE = 18'd60000;

  // Divider: one quotient bit per cycle over the 18-bit dividend.
  localparam int          DIV_BITS  = 18;
  localparam logic [4:0]  DIV_LAST  = 5'(DIV_BITS - 1);

  // Largest note table index.
  localparam int NOTE_MAX = 48;

  // Characters of interest.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;

  // Text parser phase.
  typedef enum logic [2:0] {
    PH_NAME   = 3'd0,
    PH_KEY    = 3'd1,
    PH_EQ     = 3'd2,
    PH_VAL    = 3'd3,
    PH_COUNT  = 3'd4,
    PH_SUFFIX = 3'd5
  } phase_e;

  // Header key being read.
  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_D    = 2'd1,
    KEY_O    = 2'd2,
    KEY_B    = 2'd3
  } key_e;

  // Sequencer state around the shared divider.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

  // True for an ASCII decimal digit.
  function automatic logic is_dec_char(input logic [7:0] c);
    is_dec_char = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Appends one decimal digit to the accumulator, saturating at ACC_MAX.
  function automatic logic [9:0] acc_digit(input logic [9:0] acc, input logic [7:0] c);
    logic [13:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, c[3:0]};
    acc_digit = (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[9:0];
  endfunction

  // Semitone of a note letter, c = 1 up to b = 12; zero means a rest.
  function automatic logic [3:0] letter_semitone(input logic [7:0] c);
    unique case (c)
      CH_C:    letter_semitone = 4'd1;
      CH_D:    letter_semitone = 4'd3;
      CH_E:    letter_semitone = 4'd5;
      CH_F:    letter_semitone = 4'd6;
      CH_G:    letter_semitone = 4'd8;
      CH_A:    letter_semitone = 4'd10;
      CH_B:    letter_semitone = 4'd12;
      default: letter_semitone = 4'd0;
    endcase
  endfunction

endpackage

[rtl/ringtone_text_note_parser_core.sv]
// Ringtone text note parser: top level with parser state machine and shared divider.
// Depends on rtnp_pkg and assert_macros.svh.

// The block reads a ringtone text one character per request and gives one
// result per note (pitch index, rest flag, duration in ms, error flag). Plain
// characters are accepted only while the block is idle. A ',' that closes a
// note, an end of text after a note letter, and the ':' that opens the note
// list (when the tempo is not zero) start the shared restoring divider, which
// produces one quotient bit per cycle; the block stays busy until all 18
// quotient bits are done. A note result is then loaded into the output
// register, waiting first for the output side to take the previous result,
// and the output register lets the next characters in while a result waits.
`include "assert_macros.svh"

module ringtone_text_note_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // Character requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  logic        s_axis_tlast,   // end_of_text
  // Note results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] note_index, [24:6] duration_ms, rest zero
  output logic [1:0]  m_axis_tuser    // [0] is_rest, [1] error_flag
);

  // Sequencer and parser state.
  rtnp_pkg::state_e state_q, state_d;
  rtnp_pkg::phase_e phase_q, phase_d;
  rtnp_pkg::key_e   key_q, key_d;
  logic [9:0]  acc_q, acc_d;
  logic [7:0]  dur_live_q, dur_live_d;
  logic [2:0]  oct_live_q, oct_live_d;
  logic [9:0]  tempo_live_q, tempo_live_d;
  logic [17:0] whole_q, whole_d;
  logic [3:0]  semi_q, semi_d;
  logic        dot_q, dot_d;
  logic [3:0]  note_oct_q, note_oct_d;
  logic        pend_q, pend_d;

  // Configuration registers.
  logic [7:0]  cfg_dur_q;
  logic [2:0]  cfg_oct_q;
  logic [9:0]  cfg_tempo_q;

  // Divider datapath.
  logic        div_emit_q, div_emit_d;
  logic [9:0]  div_rem_q, div_rem_d;
  logic [17:0] div_quo_q, div_quo_d;
  logic [9:0]  div_dvsr_q, div_dvsr_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [10:0] div_trial;
  logic        div_ge;
  logic [17:0] div_next_quo;
  logic [10:0] div_diff;

  // Captured note fields and output register.
  logic [5:0]  em_index_q, em_index_d;
  logic        em_rest_q, em_rest_d;
  logic        em_err_q, em_err_d;
  logic        em_dot_q, em_dot_d;
  logic        m_valid_q, m_valid_d;
  logic [5:0]  out_index_q, out_index_d;
  logic        out_rest_q, out_rest_d;
  logic [18:0] out_dur_q, out_dur_d;
  logic        out_err_q, out_err_d;

  // Helper signals.
  logic        s_accept;
  logic [7:0]  ch;
  logic        ch_digit;
  logic        do_restart;
  logic        do_emit;
  logic        do_enter;
  logic signed [8:0] oct_base;
  logic signed [8:0] pitch_idx;
  logic        pitch_bad;
  logic [9:0]  emit_dvsr;
  logic [18:0] dur_full;

  assign s_axis_tready = (state_q == rtnp_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;
  assign ch_digit      = rtnp_pkg::is_dec_char(ch);

  // Pitch index of the note being closed.
  assign oct_base  = $signed({5'd0, note_oct_q}) + 9'(rtnp_pkg::OCTAVE_SHIFT - 4);
  assign pitch_idx = (oct_base <<< 3) + (oct_base <<< 2) + $signed({5'd0, semi_q});
  assign pitch_bad = (pitch_idx < 9'sd1) || (pitch_idx > 9'(rtnp_pkg::NOTE_MAX));

  // Divisor of a note: its count, else the live default, else one.
  assign emit_dvsr = (acc_q != 10'd0) ? acc_q :
                     ((dur_live_q != 8'd0) ? {2'b00, dur_live_q} : 10'd1);

  // One restoring division step.
  assign div_trial    = {div_rem_q, div_quo_q[17]};
  assign div_diff     = div_trial - {1'b0, div_dvsr_q};
  assign div_ge       = (div_trial >= {1'b0, div_dvsr_q});
  assign div_next_quo = {div_quo_q[16:0], div_ge};

  // Duration with the dotted extension.
  assign dur_full = {1'b0, div_quo_q} + (em_dot_q ? {2'b00, div_quo_q[17:1]} : 19'd0);

  // Next state of sequencer, parser and datapath.
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    key_d        = key_q;
    acc_d        = acc_q;
    dur_live_d   = dur_live_q;
    oct_live_d   = oct_live_q;
    tempo_live_d = tempo_live_q;
    whole_d      = whole_q;
    semi_d       = semi_q;
    dot_d        = dot_q;
    note_oct_d   = note_oct_q;
    pend_d       = pend_q;
    div_emit_d   = div_emit_q;
    div_rem_d    = div_rem_q;
    div_quo_d    = div_quo_q;
    div_dvsr_d   = div_dvsr_q;
    div_cnt_d    = div_cnt_q;
    em_index_d   = em_index_q;
    em_rest_d    = em_rest_q;
    em_err_d     = em_err_q;
    em_dot_d     = em_dot_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    out_index_d  = out_index_q;
    out_rest_d   = out_rest_q;
    out_dur_d    = out_dur_q;
    out_err_d    = out_err_q;
    do_restart   = 1'b0;
    do_emit      = 1'b0;
    do_enter     = 1'b0;

    unique case (state_q)
      rtnp_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tlast) begin
            do_emit    = (phase_q == rtnp_pkg::PH_SUFFIX) && pend_q;
            do_restart = 1'b1;
          end else begin
            unique case (phase_q)
              rtnp_pkg::PH_NAME: begin
                if (ch == rtnp_pkg::CH_COLON) phase_d = rtnp_pkg::PH_KEY;
              end
              rtnp_pkg::PH_KEY: begin
                if (ch == rtnp_pkg::CH_D) begin
                  key_d   = rtnp_pkg::KEY_D;
                  phase_d = rtnp_pkg::PH_EQ;
                end else if (ch == rtnp_pkg::CH_O) begin
                  key_d   = rtnp_pkg::KEY_O;
                  phase_d = rtnp_pkg::PH_EQ;
                end else if (ch == rtnp_pkg::CH_B) begin
                  key_d   = rtnp_pkg::KEY_B;
                  phase_d = rtnp_pkg::PH_EQ;
                end else if (ch == rtnp_pkg::CH_COLON) begin
                  do_enter = 1'b1;
                end
              end
              rtnp_pkg::PH_EQ: begin
                acc_d   = 10'd0;
                phase_d = rtnp_pkg::PH_VAL;
              end
              rtnp_pkg::PH_VAL: begin
                if (ch_digit) begin
                  acc_d = rtnp_pkg::acc_digit(acc_q, ch);
                end else begin
                  // Apply the finished header value.
                  case (key_q)
                    rtnp_pkg::KEY_D: begin
                      if (acc_q != 10'd0) begin
                        dur_live_d = (acc_q > 10'd255) ? 8'd255 : acc_q[7:0];
                      end
                    end
                    rtnp_pkg::KEY_O: begin
                      if ((acc_q >= 10'd3) && (acc_q <= 10'd7)) oct_live_d = acc_q[2:0];
                    end
                    rtnp_pkg::KEY_B: tempo_live_d = acc_q;
                    default: ;
                  endcase
                  acc_d = 10'd0;
                  key_d = rtnp_pkg::KEY_NONE;
                  if (ch == rtnp_pkg::CH_COLON) begin
                    do_enter = 1'b1;
                  end else begin
                    phase_d = rtnp_pkg::PH_KEY;
                  end
                end
              end
              rtnp_pkg::PH_COUNT: begin
                if (ch_digit) begin
                  acc_d = rtnp_pkg::acc_digit(acc_q, ch);
                end else begin
                  semi_d     = rtnp_pkg::letter_semitone(ch);
                  dot_d      = 1'b0;
                  note_oct_d = {1'b0, oct_live_q};
                  pend_d     = 1'b1;
                  phase_d    = rtnp_pkg::PH_SUFFIX;
                end
              end
              rtnp_pkg::PH_SUFFIX: begin
                if (ch == rtnp_pkg::CH_HASH) begin
                  // A sharp on a rest is ignored.
                  if ((semi_q != 4'd0) && (semi_q != 4'd15)) semi_d = semi_q + 4'd1;
                end else if (ch == rtnp_pkg::CH_DOT) begin
                  dot_d = 1'b1;
                end else if (ch_digit) begin
                  note_oct_d = ch[3:0];
                end else if (ch == rtnp_pkg::CH_COMMA) begin
                  do_emit = 1'b1;
                  phase_d = rtnp_pkg::PH_COUNT;
                end
              end
              default: do_restart = 1'b1;
            endcase
          end
        end
      end
      rtnp_pkg::ST_DIV: begin
        div_rem_d = div_ge ? div_diff[9:0] : div_trial[9:0];
        div_quo_d = div_next_quo;
        div_cnt_d = div_cnt_q - 5'd1;
        if (div_cnt_q == 5'd0) begin
          if (div_emit_q) begin
            state_d = rtnp_pkg::ST_OUT;
          end else begin
            whole_d = {div_next_quo[15:0], 2'b00};
            state_d = rtnp_pkg::ST_IDLE;
          end
        end
      end
      rtnp_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d   = 1'b1;
          out_index_d = em_index_q;
          out_rest_d  = em_rest_q;
          out_err_d   = em_err_q;
          out_dur_d   = dur_full;
          state_d     = rtnp_pkg::ST_IDLE;
        end
      end
      default: state_d = rtnp_pkg::ST_IDLE;
    endcase

    // Opening the note list: whole note time from the tempo.
    if (do_enter) begin
      phase_d = rtnp_pkg::PH_COUNT;
      acc_d   = 10'd0;
      pend_d  = 1'b0;
      if (tempo_live_d == 10'd0) begin
        whole_d = 18'd0;
      end else begin
        div_emit_d = 1'b0;
        div_rem_d  = 10'd0;
        div_quo_d  = rtnp_pkg::MS_PER_MINUTE;
        div_dvsr_d = tempo_live_d;
        div_cnt_d  = rtnp_pkg::DIV_LAST;
        state_d    = rtnp_pkg::ST_DIV;
      end
    end

    // Closing a note: capture its fields and start the duration division.
    if (do_emit) begin
      em_rest_d  = (semi_q == 4'd0);
      em_err_d   = (tempo_live_q == 10'd0) || ((semi_q != 4'd0) && pitch_bad);
      em_index_d = ((semi_q == 4'd0) || pitch_bad) ? 6'd0 : pitch_idx[5:0];
      em_dot_d   = dot_q;
      div_emit_d = 1'b1;
      div_rem_d  = 10'd0;
      div_quo_d  = whole_q;
      div_dvsr_d = emit_dvsr;
      div_cnt_d  = rtnp_pkg::DIV_LAST;
      state_d    = rtnp_pkg::ST_DIV;
      acc_d      = 10'd0;
      semi_d     = 4'd0;
      dot_d      = 1'b0;
      note_oct_d = 4'd0;
      pend_d     = 1'b0;
    end

    // End of text or a bad phase: back to name skipping with fresh defaults.
    if (do_restart) begin
      phase_d      = rtnp_pkg::PH_NAME;
      key_d        = rtnp_pkg::KEY_NONE;
      acc_d        = 10'd0;
      dur_live_d   = cfg_dur_q;
      oct_live_d   = cfg_oct_q;
      tempo_live_d = cfg_tempo_q;
      whole_d      = 18'd0;
      semi_d       = 4'd0;
      dot_d        = 1'b0;
      note_oct_d   = 4'd0;
      pend_d       = 1'b0;
    end
  end

  // Control and parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rtnp_pkg::ST_IDLE;
      phase_q      <= rtnp_pkg::PH_NAME;
      key_q        <= rtnp_pkg::KEY_NONE;
      acc_q        <= 10'd0;
      dur_live_q   <= rtnp_pkg::DEF_DURATION_RST;
      oct_live_q   <= rtnp_pkg::DEF_OCTAVE_RST;
      tempo_live_q <= rtnp_pkg::DEF_TEMPO_RST;
      whole_q      <= 18'd0;
      semi_q       <= 4'd0;
      dot_q        <= 1'b0;
      note_oct_q   <= 4'd0;
      pend_q       <= 1'b0;
      div_emit_q   <= 1'b0;
      div_cnt_q    <= 5'd0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      key_q        <= key_d;
      acc_q        <= acc_d;
      dur_live_q   <= dur_live_d;
      oct_live_q   <= oct_live_d;
      tempo_live_q <= tempo_live_d;
      whole_q      <= whole_d;
      semi_q       <= semi_d;
      dot_q        <= dot_d;
      note_oct_q   <= note_oct_d;
      pend_q       <= pend_d;
      div_emit_q   <= div_emit_d;
      div_cnt_q    <= div_cnt_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dur_q   <= rtnp_pkg::DEF_DURATION_RST;
      cfg_oct_q   <= rtnp_pkg::DEF_OCTAVE_RST;
      cfg_tempo_q <= rtnp_pkg::DEF_TEMPO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rtnp_pkg::CFG_DEF_DURATION: cfg_dur_q   <= cfg_data_i[7:0];
        rtnp_pkg::CFG_DEF_OCTAVE:   cfg_oct_q   <= cfg_data_i[2:0];
        rtnp_pkg::CFG_DEF_TEMPO:    cfg_tempo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    div_rem_q   <= div_rem_d;
    div_quo_q   <= div_quo_d;
    div_dvsr_q  <= div_dvsr_d;
    em_index_q  <= em_index_d;
    em_rest_q   <= em_rest_d;
    em_err_q    <= em_err_d;
    em_dot_q    <= em_dot_d;
    out_index_q <= out_index_d;
    out_rest_q  <= out_rest_d;
    out_dur_q   <= out_dur_d;
    out_err_q   <= out_err_d;
  end

  // Output ports.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, out_dur_q, out_index_q};
  assign m_axis_tuser  = {out_err_q, out_rest_q};

  // End of text always leaves the parser skipping the name.
  `RTNP_ASSERT(a_eot_restarts, clk_i, rst_ni, s_accept && s_axis_tlast |=> phase_q == rtnp_pkg::PH_NAME)
  // A new result is only loaded from the output state.
  `RTNP_ASSERT(a_load_from_out, clk_i, rst_ni, $rose(m_valid_q) |-> $past(state_q == rtnp_pkg::ST_OUT))
  // A good note points inside the pitch table.
  `RTNP_ASSERT(a_note_in_table, clk_i, rst_ni, m_valid_q && !out_rest_q && !out_err_q |-> out_index_q != 6'd0 && out_index_q <= 6'd48)
  // A rest carries index zero.
  `RTNP_ASSERT_NEVER(a_rest_index, clk_i, rst_ni, m_valid_q && out_rest_q && out_index_q != 6'd0)
  // Duration never exceeds a dotted whole note at the slowest tempo.
  `RTNP_ASSERT(a_dur_bound, clk_i, rst_ni, m_valid_q |-> out_dur_q <= 19'd360000)

endmodule
